@@ src/wsfd_pkg.sv @@
// Shared types and constants for the frame deframer.
`default_nettype none
package wsfd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_LEN_ERR = 2'd2;

    // Frame-end actions
    localparam logic [1:0] ACT_NONE        = 2'd0;
    localparam logic [1:0] ACT_PONG        = 2'd1;
    localparam logic [1:0] ACT_CLOSE_REPLY = 2'd2;
    localparam logic [1:0] ACT_CLOSE_LINK  = 2'd3;

    // Link status
    localparam logic [1:0] LINK_CONNECTED = 2'd0;
    localparam logic [1:0] LINK_CLOSING   = 2'd1;
    localparam logic [1:0] LINK_CLOSED    = 2'd2;

    // Opcodes
    localparam logic [3:0] OP_CLOSE    = 4'h8;
    localparam logic [3:0] OP_PING     = 4'h9;
    localparam logic [3:0] OP_DATA_MIN = 4'h1;
    localparam logic [3:0] OP_DATA_MAX = 4'h7;

    // Length codes
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [15:0] CLOSE_CODE_NORMAL_MAX = 16'd1001;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic [3:0]  data_opcode;
        logic        fin_flag;
        logic        frame_last;
        logic [1:0]  action;
        logic [15:0] close_code;
        logic        close_abnormal;
    } result_t;

endpackage
`default_nettype wire

@@ src/wsfd_in_stage.sv @@
// Input register stage: holds one received byte until the parser takes it.
`default_nettype none
module wsfd_in_stage
    import wsfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            s1_valid,
    output logic [7:0]      s1_byte
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    assign in_ready = !s1_valid_reg || advance;
    assign s1_valid = s1_valid_reg;
    assign s1_byte  = s1_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

endmodule
`default_nettype wire

@@ src/wsfd_parser.sv @@
// Frame parser: header/payload state and the per-byte result logic.
`default_nettype none
module wsfd_parser
    import wsfd_pkg::*;
#(
    parameter int LEN_BITS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] b,
    output logic            res_valid,
    output result_t         res
);

    logic                in_payload_reg, in_payload_next;
    logic [3:0]          header_count_reg, header_count_next;
    logic                fin_reg, fin_next;
    logic [3:0]          cur_op_reg, cur_op_next;
    logic [3:0]          msg_op_reg, msg_op_next;
    logic                mask_on_reg, mask_on_next;
    logic [6:0]          len_code_reg, len_code_next;
    logic [31:0]         mask_key_reg, mask_key_next;
    logic [63:0]         payload_len_reg, payload_len_next;
    logic [LEN_BITS-1:0] payload_pos_reg, payload_pos_next;
    logic [15:0]         code_reg, code_next;
    logic [1:0]          link_reg, link_next;

    logic       produce;
    logic       do_end;
    logic       nonempty;
    logic [1:0] kind_c;
    logic [7:0] byte_c;
    logic       last_c;
    logic [1:0] action_c;
    logic [15:0] close_code_c;
    logic       abnormal_c;
    logic [7:0] key_byte;
    logic [7:0] ub;
    logic [4:0] total;

    function automatic logic [3:0] ext_bytes(input logic [6:0] lc);
        logic [3:0] n;
        n = 4'd0;
        if (lc == LEN_CODE_16)
        begin
            n = 4'd2;
        end
        else if (lc == LEN_CODE_64)
        begin
            n = 4'd8;
        end
        return n;
    endfunction

    always_comb
    begin
        in_payload_next   = in_payload_reg;
        header_count_next = header_count_reg;
        fin_next          = fin_reg;
        cur_op_next       = cur_op_reg;
        msg_op_next       = msg_op_reg;
        mask_on_next      = mask_on_reg;
        len_code_next     = len_code_reg;
        mask_key_next     = mask_key_reg;
        payload_len_next  = payload_len_reg;
        payload_pos_next  = payload_pos_reg;
        code_next         = code_reg;
        link_next         = link_reg;
        produce      = 1'b0;
        do_end       = 1'b0;
        nonempty     = 1'b0;
        kind_c       = KIND_PAYLOAD;
        byte_c       = 8'h00;
        last_c       = 1'b0;
        action_c     = ACT_NONE;
        close_code_c = 16'h0000;
        abnormal_c   = 1'b0;
        key_byte     = 8'h00;
        ub           = b;
        total        = 5'd0;

        if (in_payload_reg)
        begin
            case (payload_pos_reg[1:0])
                2'd0:    key_byte = mask_key_reg[31:24];
                2'd1:    key_byte = mask_key_reg[23:16];
                2'd2:    key_byte = mask_key_reg[15:8];
                default: key_byte = mask_key_reg[7:0];
            endcase
            ub = mask_on_reg ? (b ^ key_byte) : b;
            if (payload_pos_reg == '0)
            begin
                code_next = {ub, 8'h00};
            end
            else if (payload_pos_reg == LEN_BITS'(1))
            begin
                code_next = code_reg | {8'h00, ub};
            end
            payload_pos_next = payload_pos_reg + LEN_BITS'(1);
            produce  = 1'b1;
            byte_c   = ub;
            last_c   = (payload_pos_next == payload_len_reg[LEN_BITS-1:0]);
            do_end   = last_c;
            nonempty = 1'b1;
        end
        else
        begin
            if (header_count_reg == 4'd0)
            begin
                fin_next         = b[7];
                cur_op_next      = b[3:0];
                mask_on_next     = 1'b0;
                len_code_next    = 7'd0;
                mask_key_next    = 32'd0;
                payload_len_next = 64'd0;
            end
            else if (header_count_reg == 4'd1)
            begin
                mask_on_next  = b[7];
                len_code_next = b[6:0];
                if (b[6:0] < LEN_CODE_16)
                begin
                    payload_len_next = {57'd0, b[6:0]};
                end
            end
            else if ({1'b0, header_count_reg} < (5'd2 + {1'b0, ext_bytes(len_code_reg)}))
            begin
                payload_len_next = {payload_len_reg[55:0], b};
            end
            else
            begin
                mask_key_next = {mask_key_reg[23:0], b};
            end
            header_count_next = header_count_reg + 4'd1;
            total = 5'd2 + {1'b0, ext_bytes(len_code_next)} + (mask_on_next ? 5'd4 : 5'd0);

            if ({1'b0, header_count_next} >= total)
            begin
                payload_pos_next = '0;
                code_next        = 16'h0000;
                if (cur_op_next inside {[OP_DATA_MIN:OP_DATA_MAX]})
                begin
                    msg_op_next = cur_op_next;
                end
                if (len_code_next == LEN_CODE_64 && (|payload_len_next[63:LEN_BITS]))
                begin
                    produce           = 1'b1;
                    kind_c            = KIND_LEN_ERR;
                    last_c            = 1'b1;
                    action_c          = ACT_CLOSE_LINK;
                    link_next         = LINK_CLOSED;
                    payload_len_next  = 64'd0;
                    header_count_next = 4'd0;
                end
                else if (payload_len_next == 64'd0)
                begin
                    produce = 1'b1;
                    kind_c  = KIND_EMPTY;
                    last_c  = 1'b1;
                    do_end  = 1'b1;
                end
                else
                begin
                    in_payload_next = 1'b1;
                end
            end
        end

        // Frame end: control-frame follow-up, then back to header parsing
        if (do_end)
        begin
            if (cur_op_next == OP_PING)
            begin
                action_c = ACT_PONG;
            end
            else if (cur_op_next == OP_CLOSE)
            begin
                close_code_c = code_next;
                abnormal_c   = nonempty && (code_next > CLOSE_CODE_NORMAL_MAX);
                if (link_reg == LINK_CLOSING)
                begin
                    link_next = LINK_CLOSED;
                    action_c  = ACT_CLOSE_LINK;
                end
                else
                begin
                    link_next = LINK_CLOSING;
                    action_c  = ACT_CLOSE_REPLY;
                end
            end
            in_payload_next   = 1'b0;
            header_count_next = 4'd0;
        end
    end

    assign res_valid = step && produce;

    always_comb
    begin
        res.kind           = kind_c;
        res.payload_byte   = byte_c;
        res.frame_opcode   = cur_op_next;
        res.data_opcode    = msg_op_next;
        res.fin_flag       = fin_next;
        res.frame_last     = last_c;
        res.action         = action_c;
        res.close_code     = close_code_c;
        res.close_abnormal = abnormal_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg   <= 1'b0;
            header_count_reg <= 4'd0;
            fin_reg          <= 1'b0;
            cur_op_reg       <= 4'd0;
            msg_op_reg       <= 4'd0;
            mask_on_reg      <= 1'b0;
            len_code_reg     <= 7'd0;
            mask_key_reg     <= 32'd0;
            payload_len_reg  <= 64'd0;
            payload_pos_reg  <= '0;
            code_reg         <= 16'd0;
            link_reg         <= LINK_CONNECTED;
        end
        else if (step)
        begin
            in_payload_reg   <= in_payload_next;
            header_count_reg <= header_count_next;
            fin_reg          <= fin_next;
            cur_op_reg       <= cur_op_next;
            msg_op_reg       <= msg_op_next;
            mask_on_reg      <= mask_on_next;
            len_code_reg     <= len_code_next;
            mask_key_reg     <= mask_key_next;
            payload_len_reg  <= payload_len_next;
            payload_pos_reg  <= payload_pos_next;
            code_reg         <= code_next;
            link_reg         <= link_next;
        end
    end

    // While in payload the stored length is nonzero and fits in LEN_BITS bits
    a_payload_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (payload_len_reg[63:LEN_BITS] == '0 && payload_len_reg != 64'd0))
        else $error("payload length out of range while in payload");

    // A header never runs past fourteen bytes
    a_header_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !in_payload_reg |-> header_count_reg <= 4'd13)
        else $error("header byte count overran");

    // A header byte that yields a result always ends the frame
    a_header_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !in_payload_reg) |-> res.frame_last)
        else $error("header result without frame end");

endmodule
`default_nettype wire

@@ src/websocket_frame_deframer.sv @@
// Top level of the byte-serial frame deframer with its result register.
//
// Takes one received link byte per transaction and parses frame headers
// (FIN/opcode, mask bit and 7-bit length code, 16- or 64-bit extended length,
// 4-byte mask key). Header bytes give no result, except the byte that ends
// the header of an empty frame (kind 1) or of a frame whose 64-bit length
// has bits set at or above LEN_BITS (kind 2, action close link). Each payload
// byte comes out unmasked (kind 0), with frame_last on the final byte; on
// that result and on an empty frame's result, action asks for a pong after
// a ping, or for a close reply / link close after a close frame, which also
// reports its close code. While results are read the block sustains one
// byte per clock: a byte waits in the input register while its state update
// and result are formed, and the result enters the output register as the
// byte leaves. While a result waits unread, the input register holds its
// byte whether or not it makes a result; one more byte is still taken while
// that register is empty; in_ready then stays low until the result is read.
`default_nettype none
module websocket_frame_deframer
    import wsfd_pkg::*;
#(
    parameter int LEN_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic [3:0]       frame_opcode,
    output logic [3:0]       data_opcode,
    output logic             fin_flag,
    output logic             frame_last,
    output logic [1:0]       action,
    output logic [15:0]      close_code,
    output logic             close_abnormal
);

    logic       s1_valid;
    logic [7:0] s1_byte;
    logic       advance;
    logic       res_valid;
    result_t    res;

    logic       out_valid_reg;
    result_t    out_reg;

    // Advance the held byte whenever the result register is free or draining
    assign advance = s1_valid && (!out_valid_reg || out_ready);

    wsfd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte)
    );

    wsfd_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .b         (s1_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: load on a producing byte, drop on a taken transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign payload_byte   = out_reg.payload_byte;
    assign frame_opcode   = out_reg.frame_opcode;
    assign data_opcode    = out_reg.data_opcode;
    assign fin_flag       = out_reg.fin_flag;
    assign frame_last     = out_reg.frame_last;
    assign action         = out_reg.action;
    assign close_code     = out_reg.close_code;
    assign close_abnormal = out_reg.close_abnormal;

    // A length error always ends the frame and closes the link
    a_len_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_LEN_ERR) |-> (frame_last && action == ACT_CLOSE_LINK))
        else $error("length error without link close");

    // Only payload results carry a data byte
    a_byte_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_PAYLOAD) |-> payload_byte == 8'h00)
        else $error("data byte on a non-payload result");

    // Follow-up actions and close reports appear only at frame end
    a_action_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_last) |->
            (action == ACT_NONE && close_code == 16'h0000 && !close_abnormal))
        else $error("frame-end fields set mid-frame");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the byte-serial frame deframer.
`default_nettype none
module testbench;
    import wsfd_pkg::*;

    localparam int LEN_BITS    = 32;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_BYTES  = 1725;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_PRINTS  = 40;

    // Opcodes the package leaves unnamed
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam result_t NO_RESULT = '0;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic       has;
        result_t    res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic [3:0]  data_opcode;
    logic        fin_flag;
    logic        frame_last;
    logic [1:0]  action;
    logic [15:0] close_code;
    logic        close_abnormal;

    websocket_frame_deframer #(.LEN_BITS(LEN_BITS)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .frame_opcode   (frame_opcode),
        .data_opcode    (data_opcode),
        .fin_flag       (fin_flag),
        .frame_last     (frame_last),
        .action         (action),
        .close_code     (close_code),
        .close_abnormal (close_abnormal)
    );

    // Deframer state as the predictor sees it, starting from reset values
    logic        in_body    = 1'b0;
    logic [3:0]  hdr_idx    = 4'd0;
    logic        hdr_fin    = 1'b0;
    logic [3:0]  hdr_op     = 4'd0;
    logic [3:0]  msg_op     = 4'd0;
    logic        key_on     = 1'b0;
    logic [6:0]  len_code   = 7'd0;
    logic [31:0] mask_key   = 32'd0;
    logic [63:0] body_len   = 64'd0;
    logic [31:0] body_pos   = 32'd0;
    logic [15:0] close_word = 16'd0;
    logic [1:0]  link_state = LINK_CONNECTED;

    result_t  pending_results[$];
    dir_row_t dir_table [DIR_ROWS];

    // Expectation source for the byte currently offered
    logic    row_typed = 1'b0;
    logic    row_has   = 1'b0;
    result_t row_res   = '0;

    int send_stall_pct = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int quiet_cycles   = 0;
    int n_bytes        = 0;
    int n_frames       = 0;
    int n_noise        = 0;
    int n_checked      = 0;
    int kind_seen [4]  = '{0, 0, 0, 0};
    int act_seen  [4]  = '{0, 0, 0, 0};

    function automatic result_t frame_result(logic [1:0] k, logic [7:0] d, logic last);
        result_t r;
        r                = '0;
        r.kind           = k;
        r.payload_byte   = d;
        r.frame_opcode   = hdr_op;
        r.data_opcode    = msg_op;
        r.fin_flag       = hdr_fin;
        r.frame_last     = last;
        return r;
    endfunction

    // Frame-end bookkeeping: pong request, close code and link transitions
    function automatic void finish_frame(inout result_t r);
        if (hdr_op == OP_PING)
        begin
            r.action = ACT_PONG;
        end
        else if (hdr_op == OP_CLOSE)
        begin
            r.close_code     = close_word;
            r.close_abnormal = (body_len != 0) && (close_word > CLOSE_CODE_NORMAL_MAX);
            if (link_state == LINK_CLOSING)
            begin
                link_state = LINK_CLOSED;
                r.action   = ACT_CLOSE_LINK;
            end
            else
            begin
                link_state = LINK_CLOSING;
                r.action   = ACT_CLOSE_REPLY;
            end
        end
        in_body = 1'b0;
        hdr_idx = 4'd0;
    endfunction

    // Advance the predicted state by one link byte; return 1 if it yields a result
    function automatic bit deframe_byte(logic [7:0] b, output result_t r);
        int         idx;
        int         ext;
        int         total;
        int         sh;
        logic [7:0] d;
        r = '0;
        if (in_body)
        begin
            sh = (3 - int'(body_pos[1:0])) * 8;
            d  = key_on ? (b ^ mask_key[sh +: 8]) : b;
            if (body_pos == 0)
                close_word = {d, 8'h00};
            else if (body_pos == 1)
                close_word[7:0] = d;
            body_pos = body_pos + 1;
            if ({32'd0, body_pos} == body_len)
            begin
                r = frame_result(KIND_PAYLOAD, d, 1'b1);
                finish_frame(r);
            end
            else
            begin
                r = frame_result(KIND_PAYLOAD, d, 1'b0);
            end
            return 1'b1;
        end

        idx = hdr_idx;
        ext = (len_code == LEN_CODE_16) ? 2 : ((len_code == LEN_CODE_64) ? 8 : 0);
        if (idx == 0)
        begin
            hdr_fin  = b[7];
            hdr_op   = b[3:0];
            key_on   = 1'b0;
            len_code = 7'd0;
            mask_key = 32'd0;
            body_len = 64'd0;
        end
        else if (idx == 1)
        begin
            key_on   = b[7];
            len_code = b[6:0];
            if (len_code < LEN_CODE_16)
                body_len = {57'd0, len_code};
        end
        else if (idx < 2 + ext)
        begin
            body_len = {body_len[55:0], b};
        end
        else
        begin
            mask_key = {mask_key[23:0], b};
        end
        hdr_idx = hdr_idx + 4'd1;
        ext   = (len_code == LEN_CODE_16) ? 2 : ((len_code == LEN_CODE_64) ? 8 : 0);
        total = 2 + ext + (key_on ? 4 : 0);
        if (int'(hdr_idx) < total)
            return 1'b0;

        body_pos   = 32'd0;
        close_word = 16'd0;
        if (hdr_op >= OP_DATA_MIN && hdr_op <= OP_DATA_MAX)
            msg_op = hdr_op;
        if (len_code == LEN_CODE_64 && (body_len >> LEN_BITS) != 0)
        begin
            r          = frame_result(KIND_LEN_ERR, 8'h00, 1'b1);
            r.action   = ACT_CLOSE_LINK;
            link_state = LINK_CLOSED;
            body_len   = 64'd0;
            in_body    = 1'b0;
            hdr_idx    = 4'd0;
            return 1'b1;
        end
        if (body_len == 0)
        begin
            r = frame_result(KIND_EMPTY, 8'h00, 1'b1);
            finish_frame(r);
            return 1'b1;
        end
        in_body = 1'b1;
        return 1'b0;
    endfunction

    task automatic report_error(string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_error($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                   n_checked, name, got, want));
    endtask

    // Offer one byte, idling first at the current rate; return on the falling
    // edge after the transaction.
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(0, 99) < send_stall_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        n_bytes++;
        @(negedge clk);
    endtask

    // One well-formed frame with random header choices and content
    task automatic send_frame();
        logic [3:0]  op;
        logic        fin;
        logic [2:0]  rsv;
        logic        masked;
        logic [31:0] key;
        logic [31:0] upper;
        logic [6:0]  code7;
        logic [63:0] len;
        logic [15:0] ccode;
        logic [7:0]  plain;
        logic        oversize;
        int          sel;
        case ($urandom_range(0, 9))
            0, 1:    op = OP_CONT;
            2, 3:    op = OP_TEXT;
            4:       op = OP_BINARY;
            5:       op = 4'($urandom_range(0, 15));
            6:       op = OP_PING;
            7, 8:    op = OP_CLOSE;
            default: op = OP_PONG;
        endcase
        fin      = 1'($urandom_range(0, 1));
        rsv      = 3'($urandom_range(0, 7));
        masked   = 1'($urandom_range(0, 1));
        key      = $urandom;
        oversize = 1'b0;
        sel      = $urandom_range(0, 19);
        if (sel <= 2)
            len = 64'd0;
        else if (sel <= 12)
            len = (op == OP_CLOSE && $urandom_range(0, 1)) ? 64'd2 : 64'($urandom_range(1, 8));
        else if (sel == 13)
            len = 64'($urandom_range(9, 125));
        else if (sel <= 15)
            len = 64'($urandom_range(0, 300));
        else if (sel <= 17)
            len = 64'($urandom_range(0, 40));
        else if (sel == 18)
        begin
            // set a single upper-half bit alone half the time
            upper    = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31)) : ($urandom | 32'h1);
            len      = {upper, $urandom};
            oversize = 1'b1;
        end
        else
            len = 64'd2;
        if (sel >= 16 && sel <= 18)
            code7 = LEN_CODE_64;
        else if (sel >= 14 && sel <= 15)
            code7 = LEN_CODE_16;
        else
            code7 = len[6:0];
        case ($urandom_range(0, 3))
            0:       ccode = CLOSE_CODE_NORMAL_MAX;
            1:       ccode = CLOSE_CODE_NORMAL_MAX + 16'd1;
            2:       ccode = CLOSE_CODE_NORMAL_MAX - 16'd1;
            default: ccode = 16'($urandom);
        endcase

        n_frames++;
        send_byte({fin, rsv, op});
        send_byte({masked, code7});
        if (code7 == LEN_CODE_16)
        begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else if (code7 == LEN_CODE_64)
        begin
            for (int i = 7; i >= 0; i--)
                send_byte(len[i*8 +: 8]);
        end
        if (masked)
        begin
            for (int i = 3; i >= 0; i--)
                send_byte(key[i*8 +: 8]);
        end
        if (!oversize)
        begin
            for (int i = 0; i < int'(len); i++)
            begin
                plain = (op == OP_CLOSE && i < 2) ? ccode[(1-i)*8 +: 8] : 8'($urandom);
                send_byte(masked ? (plain ^ key[(3 - i % 4)*8 +: 8]) : plain);
            end
        end
    endtask

    // Garbage bytes, then more until the stream lands on a header boundary.
    // Hold extended lengths short so a broken header cannot swallow the run.
    task automatic send_noise();
        logic [7:0]  b;
        logic [31:0] upper;
        int          n;
        int          k;
        n = $urandom_range(1, 6);
        k = 0;
        n_noise++;
        while (k < n || in_body || hdr_idx != 0)
        begin
            b = 8'($urandom);
            if (!in_body && hdr_idx >= 2)
            begin
                if (len_code == LEN_CODE_16 && hdr_idx == 2)
                    b = b & 8'h01;
                else if (len_code == LEN_CODE_64 && hdr_idx <= 5 && $urandom_range(0, 1))
                    b = 8'h00;
                else if (len_code == LEN_CODE_64 && hdr_idx >= 6 && hdr_idx <= 8)
                begin
                    upper = 32'(body_len >> (8 * (int'(hdr_idx) - 6)));
                    if (upper == 0)
                        b = 8'h00;
                end
            end
            send_byte(b);
            k++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Predict on every input transaction, check every output transaction
    always @(posedge clk)
    begin : result_check
        result_t pred;
        result_t got;
        result_t want;
        bit      has;
        if (rst_n)
        begin
            if (in_valid && in_ready === 1'b1)
            begin
                has = deframe_byte(rx_byte, pred);
                if (row_typed)
                begin
                    if (row_has)
                        pending_results.push_back(row_res);
                end
                else if (has)
                begin
                    pending_results.push_back(pred);
                end
            end
            if (out_valid === 1'b1 && out_ready)
            begin
                got = {kind, payload_byte, frame_opcode, data_opcode, fin_flag,
                       frame_last, action, close_code, close_abnormal};
                if (pending_results.size() == 0)
                begin
                    report_error($sformatf("result with nothing pending: 0x%0h", got));
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", 16'(got.kind), 16'(want.kind));
                    check_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
                    check_field("frame_opcode", 16'(got.frame_opcode), 16'(want.frame_opcode));
                    check_field("data_opcode", 16'(got.data_opcode),
                                16'(want.data_opcode));
                    check_field("fin_flag", 16'(got.fin_flag), 16'(want.fin_flag));
                    check_field("frame_last", 16'(got.frame_last), 16'(want.frame_last));
                    check_field("action", 16'(got.action), 16'(want.action));
                    check_field("close_code", got.close_code, want.close_code);
                    check_field("close_abnormal", 16'(got.close_abnormal),
                                16'(want.close_abnormal));
                    kind_seen[want.kind]++;
                    act_seen[want.action]++;
                    n_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d results pending",
                     QUIET_LIMIT, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = 8'h00;
        out_ready = 1'b0;

        dir_table = '{
            // empty final text frame
            '{8'h81, 1'b1, 1'b0, NO_RESULT},
            '{8'h00, 1'b1, 1'b1, '{KIND_EMPTY, 8'h00, OP_TEXT, OP_TEXT, 1'b1, 1'b1,
                                   ACT_NONE, 16'h0000, 1'b0}},
            // masked one-byte ping: key byte 0xFF cancels the payload
            '{8'h89, 1'b1, 1'b0, NO_RESULT},
            '{8'h81, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h00, OP_PING, OP_TEXT, 1'b1, 1'b1,
                                   ACT_PONG, 16'h0000, 1'b0}},
            // close with the largest code while connected
            '{8'h88, 1'b0, 1'b0, NO_RESULT},
            '{8'h02, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'hFF, OP_CLOSE, OP_TEXT, 1'b1, 1'b1,
                                   ACT_CLOSE_REPLY, 16'hFFFF, 1'b1}},
            // binary fragment with a 64-bit length that has bit 63 set
            '{8'h02, 1'b0, 1'b0, NO_RESULT},
            '{8'h7F, 1'b0, 1'b0, NO_RESULT},
            '{8'h80, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b1, 1'b1, '{KIND_LEN_ERR, 8'h00, OP_BINARY, OP_BINARY, 1'b0, 1'b1,
                                   ACT_CLOSE_LINK, 16'h0000, 1'b0}},
            // empty close on a closed link asks for a reply again
            '{8'h88, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b1, 1'b1, '{KIND_EMPTY, 8'h00, OP_CLOSE, OP_BINARY, 1'b1, 1'b1,
                                   ACT_CLOSE_REPLY, 16'h0000, 1'b0}}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_stall_pct = 24;
        recv_stall_pct = 80;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row_typed = dir_table[i].typed;
            row_has   = dir_table[i].has;
            row_res   = dir_table[i].res;
            send_byte(dir_table[i].data);
        end
        row_typed = 1'b0;

        // Three idling profiles; drain fully between them
        for (int phase = 0; phase < 3; phase++)
        begin
            send_stall_pct = (phase == 0) ? 24 : ((phase == 1) ? 80 : 0);
            recv_stall_pct = (phase == 0) ? 80 : ((phase == 1) ? 24 : 0);
            while (n_bytes < DIR_ROWS + (phase + 1) * (RAND_BYTES / 3))
            begin
                if ($urandom_range(0, 99) < 8)
                    send_noise();
                else
                    send_frame();
            end
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            @(negedge clk);
        end

        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run: %0d link bytes, %0d random frames, %0d noise bursts, %0d results checked",
                 n_bytes, n_frames, n_noise, n_checked);
        $display({"results: %0d payload, %0d empty, %0d length errors; ",
                  "%0d pongs, %0d close replies, %0d link closes"},
                 kind_seen[KIND_PAYLOAD], kind_seen[KIND_EMPTY], kind_seen[KIND_LEN_ERR],
                 act_seen[ACT_PONG], act_seen[ACT_CLOSE_REPLY], act_seen[ACT_CLOSE_LINK]);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

@@ websocket_frame_deframer.f @@
src/wsfd_pkg.sv
src/wsfd_in_stage.sv
src/wsfd_parser.sv
src/websocket_frame_deframer.sv
sim/testbench.sv
